[rtl/dmm_pkg.sv]
// Package for the deletable max multiset block.
// Shared types, operation/status codes and constants. No dependencies.
package dmm_pkg;

  localparam int VAL_W   = 31;
  localparam int COUNT_W = 11;

  // Reported as the maximum when the store is empty (-0x3f3f3f3f)
  localparam logic signed [VAL_W-1:0] EMPTY_MARK = -31'sd1061109567;

  // Operation codes carried in func
  localparam logic FUNC_REMOVE = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the input beat, clear scan state
    logic insert;   // append the value and update the top two
    logic scan;     // issue one memory read for the search pass
    logic finish;   // commit a remove
    logic respond;  // load the result register
  } dmm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_insert;  // incoming beat is an insert
    logic empty;      // store holds nothing
    logic scan_last;  // the read issued now is the last held entry
  } dmm_sts_t;

endpackage

[rtl/dmm_if.sv]
// Channel interfaces for the deletable max multiset block.
// Valid/ready channels for input beats and result beats; widths are written out to match dmm_pkg.
interface dmm_in_if;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [31-1:0]    value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface dmm_out_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [31-1:0]    best_value;
  logic [31-1:0]           pair_sum;
  logic [11-1:0]           count;

  modport source (output valid, output status, output best_value, output pair_sum,
                  output count, input ready);
  modport sink   (input valid, input status, input best_value, input pair_sum,
                  input count, output ready);
endinterface

[rtl/dmm_ctrl.sv]
// Controller for the deletable max multiset block.
// Sequences insert, search pass and result beat; depends on dmm_pkg.
module dmm_ctrl
  import dmm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dmm_cmd_t cmd,
  input  dmm_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_SCAN,
    S_DRAIN,
    S_FIN,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire, out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_ready && in_valid;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Commands follow the state
  always_comb begin
    cmd         = '0;
    cmd.load    = in_fire;
    cmd.insert  = (state_r == S_INS);
    cmd.scan    = (state_r == S_SCAN);
    cmd.finish  = (state_r == S_FIN);
    cmd.respond = (state_r == S_RESP) && out_free;
  end

  // Next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (sts.in_insert)  state_nxt = S_INS;
          else if (sts.empty) state_nxt = S_FIN;
          else                state_nxt = S_SCAN;
        end
      end
      S_INS:   state_nxt = S_RESP;
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN:   state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/dmm_dp.sv]
// Datapath for the deletable max multiset block.
// Entry memory, held count, top-two registers, search pass and result register.
// Depends on dmm_pkg.
module dmm_dp
  import dmm_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dmm_cmd_t                cmd,
  output dmm_sts_t                sts,
  input  logic                    in_func,
  input  logic signed [VAL_W-1:0] in_value,
  output logic [1:0]              res_status,
  output logic signed [VAL_W-1:0] res_best,
  output logic [VAL_W-1:0]        res_pair,
  output logic [COUNT_W-1:0]      res_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HW = $clog2(CAPACITY + 1);

  // Unordered store: entries 0..held-1 are live
  logic signed [VAL_W-1:0] entries_r [CAPACITY];

  logic signed [VAL_W-1:0] val_r;
  logic [HW-1:0]           held_r;
  logic signed [VAL_W-1:0] top1_r, top2_r;
  logic [HW-1:0]           cnt_r;
  logic                    rd_vld_r;
  logic signed [VAL_W-1:0] rd_q_r;
  logic [AW-1:0]           rd_qa_r;
  logic                    found_r;
  logic [AW-1:0]           found_addr_r;
  logic signed [VAL_W-1:0] last_r;
  logic signed [VAL_W-1:0] sc1_r, sc2_r;
  logic                    sc1_ok_r, sc2_ok_r;
  status_t                 status_r;

  logic [1:0]              res_status_r;
  logic signed [VAL_W-1:0] res_best_r;
  logic [VAL_W-1:0]        res_pair_r;
  logic [COUNT_W-1:0]      res_count_r;

  logic                    full, skip;
  logic [HW-1:0]           held_m1;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic signed [VAL_W-1:0] mem_wd;
  logic signed [VAL_W:0]   pair_full;

  assign full    = (held_r == HW'(CAPACITY));
  assign held_m1 = held_r - HW'(1);

  assign sts.in_insert = (in_func == FUNC_INSERT);
  assign sts.empty     = (held_r == '0);
  assign sts.scan_last = (cnt_r == held_m1);

  // Single write port: append on insert, backfill the hole on remove
  assign mem_we = (cmd.insert && !full) || (cmd.finish && found_r);
  assign mem_wa = cmd.insert ? held_r[AW-1:0] : found_addr_r;
  assign mem_wd = cmd.insert ? val_r : last_r;

  always_ff @(posedge clk) begin
    if (mem_we) entries_r[mem_wa] <= mem_wd;
    if (cmd.scan) begin
      rd_q_r  <= entries_r[cnt_r[AW-1:0]];
      rd_qa_r <= cnt_r[AW-1:0];
    end
  end

  // First match of the searched value is left out of the top-two pass
  assign skip = !found_r && (rd_q_r == val_r);

  // Search pass and top-two accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      sc1_ok_r <= 1'b0;
      sc2_ok_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        cnt_r    <= '0;
        found_r  <= 1'b0;
        sc1_ok_r <= 1'b0;
        sc2_ok_r <= 1'b0;
      end else begin
        if (cmd.scan) cnt_r <= cnt_r + HW'(1);
        if (rd_vld_r) begin
          last_r <= rd_q_r;
          if (skip) begin
            found_r      <= 1'b1;
            found_addr_r <= rd_qa_r;
          end else if (!sc1_ok_r) begin
            sc1_r    <= rd_q_r;
            sc1_ok_r <= 1'b1;
          end else if (rd_q_r > sc1_r) begin
            sc2_r    <= sc1_r;
            sc2_ok_r <= 1'b1;
            sc1_r    <= rd_q_r;
          end else if (!sc2_ok_r || rd_q_r > sc2_r) begin
            sc2_r    <= rd_q_r;
            sc2_ok_r <= 1'b1;
          end
        end
      end
    end
  end

  // Held count, top two and status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      status_r <= ST_DONE;
    end else begin
      if (cmd.load) val_r <= in_value;
      if (cmd.insert) begin
        if (full) begin
          status_r <= ST_FULL;
        end else begin
          status_r <= ST_DONE;
          held_r   <= held_r + HW'(1);
          if (held_r == '0) begin
            top1_r <= val_r;
          end else if (val_r > top1_r) begin
            top2_r <= top1_r;
            top1_r <= val_r;
          end else if (held_r == HW'(1) || val_r > top2_r) begin
            top2_r <= val_r;
          end
        end
      end
      if (cmd.finish) begin
        if (found_r) begin
          status_r <= ST_DONE;
          held_r   <= held_m1;
          top1_r   <= sc1_r;
          top2_r   <= sc2_r;
        end else begin
          status_r <= ST_ABSENT;
        end
      end
    end
  end

  // Result register
  assign pair_full = {top1_r[VAL_W-1], top1_r} + {top2_r[VAL_W-1], top2_r};

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      res_status_r <= status_r;
      res_best_r   <= (held_r != '0) ? top1_r : EMPTY_MARK;
      if (held_r < HW'(2) || pair_full[VAL_W]) res_pair_r <= '0;
      else                                     res_pair_r <= pair_full[VAL_W-1:0];
      res_count_r  <= COUNT_W'(held_r);
    end
  end

  assign res_status = res_status_r;
  assign res_best   = res_best_r;
  assign res_pair   = res_pair_r;
  assign res_count  = res_count_r;

endmodule

[rtl/deletable_max_multiset.sv]
// Top level of the deletable max multiset block.
// Joins dmm_ctrl and dmm_dp to the channel interfaces; depends on dmm_pkg, dmm_if.
//
//   channel  dir  payload                                  beat when
//   in_ch    in   func, value                              valid & ready
//   out_ch   out  status, best_value, pair_sum, count      valid & ready
//
// One item at a time. An insert passes through the insert and respond states from acceptance to result.
// A remove reads every held entry through the single memory read port (none
// when the store is empty), then commits and responds.
// Reset clears the held count, status and scan state; the entry memory needs no clearing.
// A stalled result holds in the output register; the next item is taken once
// the result has been loaded there.
module deletable_max_multiset
  import dmm_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  dmm_in_if.sink    in_ch,
  dmm_out_if.source out_ch
);

  dmm_cmd_t cmd;
  dmm_sts_t sts;

  dmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dmm_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (in_ch.func),
    .in_value   (in_ch.value),
    .res_status (out_ch.status),
    .res_best   (out_ch.best_value),
    .res_pair   (out_ch.pair_sum),
    .res_count  (out_ch.count)
  );

endmodule
